>>> src/dmc_pkg.sv
// Shared constants and controller/datapath interface types for the direct-mapped cache.
`default_nettype none

package dmc_pkg;

  localparam int unsigned ADDR_W     = 12;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned LINE_OUT_W = 5;
  localparam int unsigned TAG_OUT_W  = 4;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // One step command from the controller to the datapath.
  typedef struct packed {
    logic init;
    logic capture;
    logic mem_mul;
    logic mem_fix;
    logic blk_mul;
    logic blk_fix;
    logic ln_mul;
    logic ln_fix;
    logic tag_rd;
    logic lookup;
    logic fill_rd;
    logic fill_wr;
    logic tag_wr;
    logic access;
  } cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic init_last;
    logic hit;
    logic fill_last;
  } sts_t;

endpackage

`default_nettype wire

>>> src/dmc_datapath.sv
// Datapath of the direct-mapped cache: address split, tag store, data store, backing memory.
`default_nettype none

module dmc_datapath
  import dmc_pkg::*;
#(
  parameter int unsigned MEM_WORDS   = 4096,
  parameter int unsigned CACHE_WORDS = 256,
  parameter int unsigned BLOCK_WORDS = 8
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  cmd_t                         cmd_i,
  output sts_t                         sts_o,
  input  wire                          op_i,
  input  wire        [ADDR_W-1:0]      address_i,
  input  wire        [DATA_W-1:0]      write_value_i,
  output logic                         hit_o,
  output logic       [LINE_OUT_W-1:0]  line_index_o,
  output logic       [TAG_OUT_W-1:0]   tag_value_o,
  output logic signed [DATA_W-1:0]     read_value_o
);

  localparam int unsigned NUM_LINES =
      (CACHE_WORDS / BLOCK_WORDS) > 0 ? (CACHE_WORDS / BLOCK_WORDS) : 1;
  localparam int unsigned DATA_DEPTH = NUM_LINES * BLOCK_WORDS;
  localparam int unsigned ADDR_SPAN  = MEM_WORDS < (1 << ADDR_W) ? MEM_WORDS : (1 << ADDR_W);
  localparam int unsigned BLK_MAX    = (ADDR_SPAN - 1) / BLOCK_WORDS;
  localparam int unsigned TAG_MAX    = BLK_MAX / NUM_LINES;
  localparam int unsigned INIT_LEN   = MEM_WORDS > NUM_LINES ? MEM_WORDS : NUM_LINES;

  localparam int unsigned AW_MEM = $clog2(MEM_WORDS);
  localparam int unsigned LW     = NUM_LINES > 1 ? $clog2(NUM_LINES) : 1;
  localparam int unsigned OFF_W  = BLOCK_WORDS > 1 ? $clog2(BLOCK_WORDS) : 1;
  localparam int unsigned BLK_W  = BLK_MAX > 0 ? $clog2(BLK_MAX + 1) : 1;
  localparam int unsigned TAG_W  = TAG_MAX > 0 ? $clog2(TAG_MAX + 1) : 1;
  localparam int unsigned DIDX_W = DATA_DEPTH > 1 ? $clog2(DATA_DEPTH) : 1;
  localparam int unsigned CW     = $clog2(INIT_LEN);

  // Division by a constant: q = (x * M) >> S is exact for every x below 2**ADDR_W
  // when S = ADDR_W + ceil(log2 D) and M = ceil(2**S / D).
  localparam int unsigned MUL_W  = ADDR_W + 2;
  localparam int unsigned PROD_W = ADDR_W + MUL_W;
  localparam int unsigned S0 = ADDR_W + $clog2(MEM_WORDS);
  localparam int unsigned S1 = ADDR_W + $clog2(BLOCK_WORDS);
  localparam int unsigned S2 = ADDR_W + $clog2(NUM_LINES);
  localparam longint unsigned M0_L = ((64'd1 << S0) + MEM_WORDS - 1) / MEM_WORDS;
  localparam longint unsigned M1_L = ((64'd1 << S1) + BLOCK_WORDS - 1) / BLOCK_WORDS;
  localparam longint unsigned M2_L = ((64'd1 << S2) + NUM_LINES - 1) / NUM_LINES;
  localparam logic [MUL_W-1:0] M0 = MUL_W'(M0_L);
  localparam logic [MUL_W-1:0] M1 = MUL_W'(M1_L);
  localparam logic [MUL_W-1:0] M2 = MUL_W'(M2_L);

  // Storage.
  logic [DATA_W-1:0] backing_q [MEM_WORDS];
  logic [DATA_W-1:0] cache_q   [DATA_DEPTH];
  logic [TAG_W:0]    tags_q    [NUM_LINES];

  // Transaction registers.
  logic              op_q;
  logic [ADDR_W-1:0] addr_in_q;
  logic [ADDR_W-1:0] addr_q;
  logic [DATA_W-1:0] wval_q;
  logic [BLK_W-1:0]  block_q;
  logic [OFF_W-1:0]  off_q;
  logic [LW-1:0]     line_q;
  logic [TAG_W-1:0]  tag_q;
  logic [DIDX_W-1:0] base_q;
  logic [PROD_W-1:0] prod_q;
  logic [TAG_W:0]    tag_rd_q;
  logic              hit_q;
  logic [AW_MEM-1:0] ptr_q;
  logic [OFF_W-1:0]  fill_cnt_q;
  logic [DATA_W-1:0] mem_rd_q;
  logic [DATA_W-1:0] data_rd_q;
  logic [CW-1:0]     init_cnt_q;

  // Combinational helpers.
  logic [ADDR_W-1:0] mul_x;
  logic [MUL_W-1:0]  mul_m;
  logic [ADDR_W-1:0] q0, q1, q2;
  logic              is_write;
  logic              init_mem_in;
  logic              init_tag_in;
  logic              mem_we;
  logic [AW_MEM-1:0] mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              cache_we;
  logic [DIDX_W-1:0] cache_widx;
  logic [DIDX_W-1:0] access_idx;
  logic [DATA_W-1:0] cache_wdata;
  logic              tag_we;
  logic [LW-1:0]     tag_widx;
  logic [TAG_W:0]    tag_wdata;

  assign is_write    = (op_q == OP_WRITE);
  assign init_mem_in = 32'(init_cnt_q) < MEM_WORDS;
  assign init_tag_in = 32'(init_cnt_q) < NUM_LINES;
  assign access_idx  = DIDX_W'(32'(base_q) + 32'(off_q));

  always_comb begin
    if (cmd_i.mem_mul) begin
      mul_x = addr_in_q;
      mul_m = M0;
    end else if (cmd_i.blk_mul) begin
      mul_x = addr_q;
      mul_m = M1;
    end else begin
      mul_x = ADDR_W'(block_q);
      mul_m = M2;
    end
  end

  assign q0 = ADDR_W'(prod_q >> S0);
  assign q1 = ADDR_W'(prod_q >> S1);
  assign q2 = ADDR_W'(prod_q >> S2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_cnt_q <= '0;
    end else if (cmd_i.init && !sts_o.init_last) begin
      init_cnt_q <= init_cnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q      <= op_i;
      addr_in_q <= address_i;
      wval_q    <= write_value_i;
    end
    if (cmd_i.mem_mul || cmd_i.blk_mul || cmd_i.ln_mul) begin
      prod_q <= PROD_W'(mul_x) * PROD_W'(mul_m);
    end
    if (cmd_i.mem_fix) begin
      addr_q <= ADDR_W'(32'(addr_in_q) - 32'(q0) * 32'(MEM_WORDS));
    end
    if (cmd_i.blk_fix) begin
      block_q <= BLK_W'(q1);
      off_q   <= OFF_W'(32'(addr_q) - 32'(q1) * 32'(BLOCK_WORDS));
    end
    if (cmd_i.ln_fix) begin
      tag_q  <= TAG_W'(q2);
      line_q <= LW'(32'(block_q) - 32'(q2) * 32'(NUM_LINES));
    end
    if (cmd_i.tag_rd) begin
      tag_rd_q <= tags_q[line_q];
      base_q   <= DIDX_W'(32'(line_q) * 32'(BLOCK_WORDS));
    end
    if (cmd_i.lookup) begin
      hit_q      <= sts_o.hit;
      ptr_q      <= AW_MEM'(32'(addr_q) - 32'(off_q));
      fill_cnt_q <= '0;
    end
    if (cmd_i.fill_rd) begin
      // The fill walks the block and wraps at the end of backing memory.
      ptr_q <= (ptr_q == AW_MEM'(MEM_WORDS - 1)) ? '0 : ptr_q + AW_MEM'(1);
    end
    if (cmd_i.fill_wr) begin
      fill_cnt_q <= fill_cnt_q + OFF_W'(1);
    end
  end

  // Backing memory: one write port, one registered read port.
  always_comb begin
    if (cmd_i.init) begin
      mem_we    = init_mem_in;
      mem_waddr = AW_MEM'(init_cnt_q);
      mem_wdata = 32'(MEM_WORDS) - 32'(init_cnt_q);
    end else begin
      mem_we    = cmd_i.access && is_write;
      mem_waddr = AW_MEM'(addr_q);
      mem_wdata = wval_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      backing_q[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.fill_rd) begin
      mem_rd_q <= backing_q[ptr_q];
    end
  end

  // Cache data store.
  always_comb begin
    if (cmd_i.fill_wr) begin
      cache_we    = 1'b1;
      cache_widx  = DIDX_W'(32'(base_q) + 32'(fill_cnt_q));
      cache_wdata = mem_rd_q;
    end else begin
      cache_we    = cmd_i.access && is_write;
      cache_widx  = access_idx;
      cache_wdata = wval_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cache_we) begin
      cache_q[cache_widx] <= cache_wdata;
    end
    if (cmd_i.access && !is_write) begin
      data_rd_q <= cache_q[access_idx];
    end
  end

  // Tag store, each entry a valid bit above the tag.
  always_comb begin
    if (cmd_i.init) begin
      tag_we    = init_tag_in;
      tag_widx  = LW'(init_cnt_q);
      tag_wdata = '0;
    end else begin
      tag_we    = cmd_i.tag_wr;
      tag_widx  = line_q;
      tag_wdata = {1'b1, tag_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (tag_we) begin
      tags_q[tag_widx] <= tag_wdata;
    end
  end

  assign sts_o.init_last = (init_cnt_q == CW'(INIT_LEN - 1));
  assign sts_o.hit       = tag_rd_q[TAG_W] && (tag_rd_q[TAG_W-1:0] == tag_q);
  assign sts_o.fill_last = (fill_cnt_q == OFF_W'(BLOCK_WORDS - 1));

  assign hit_o        = hit_q;
  assign line_index_o = LINE_OUT_W'(line_q);
  assign tag_value_o  = TAG_OUT_W'(tag_q);
  assign read_value_o = is_write ? wval_q : data_rd_q;

endmodule

`default_nettype wire

>>> src/dmc_ctrl.sv
// Controller state machine of the direct-mapped cache.
`default_nettype none

module dmc_ctrl
  import dmc_pkg::*;
(
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   start,
  output logic  busy,
  output logic  done_o,
  output cmd_t  cmd_o,
  input  sts_t  sts_i
);

  typedef enum logic [13:0] {
    ST_INIT     = 14'b00000000000001,
    ST_IDLE     = 14'b00000000000010,
    ST_MEM_MUL  = 14'b00000000000100,
    ST_MEM_FIX  = 14'b00000000001000,
    ST_BLK_MUL  = 14'b00000000010000,
    ST_BLK_FIX  = 14'b00000000100000,
    ST_LN_MUL   = 14'b00000001000000,
    ST_LN_FIX   = 14'b00000010000000,
    ST_TAG_RD   = 14'b00000100000000,
    ST_LOOKUP   = 14'b00001000000000,
    ST_FILL_RD  = 14'b00010000000000,
    ST_FILL_WR  = 14'b00100000000000,
    ST_ACCESS   = 14'b01000000000000,
    ST_RESP     = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.init = 1'b1;
        if (sts_i.init_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_MEM_MUL;
        end
      end
      ST_MEM_MUL: begin
        cmd_o.mem_mul = 1'b1;
        state_d       = ST_MEM_FIX;
      end
      ST_MEM_FIX: begin
        cmd_o.mem_fix = 1'b1;
        state_d       = ST_BLK_MUL;
      end
      ST_BLK_MUL: begin
        cmd_o.blk_mul = 1'b1;
        state_d       = ST_BLK_FIX;
      end
      ST_BLK_FIX: begin
        cmd_o.blk_fix = 1'b1;
        state_d       = ST_LN_MUL;
      end
      ST_LN_MUL: begin
        cmd_o.ln_mul = 1'b1;
        state_d      = ST_LN_FIX;
      end
      ST_LN_FIX: begin
        cmd_o.ln_fix = 1'b1;
        state_d      = ST_TAG_RD;
      end
      ST_TAG_RD: begin
        cmd_o.tag_rd = 1'b1;
        state_d      = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        state_d      = sts_i.hit ? ST_ACCESS : ST_FILL_RD;
      end
      ST_FILL_RD: begin
        cmd_o.fill_rd = 1'b1;
        state_d       = ST_FILL_WR;
      end
      ST_FILL_WR: begin
        cmd_o.fill_wr = 1'b1;
        if (sts_i.fill_last) begin
          // The tag is recorded together with the last word of the block.
          cmd_o.tag_wr = 1'b1;
          state_d      = ST_ACCESS;
        end else begin
          state_d = ST_FILL_RD;
        end
      end
      ST_ACCESS: begin
        cmd_o.access = 1'b1;
        state_d      = ST_RESP;
      end
      ST_RESP: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_RESP);

  // A result frees the block for the next transaction right away.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !busy)
    else $error("block still busy after delivering a result");

  // An accepted transaction never produces a result in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (start && !busy) |=> (busy && !done_o))
    else $error("accepted transaction did not keep the block busy");

  // Exactly one result per transaction: strobes never come back to back.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

endmodule

`default_nettype wire

>>> src/direct_mapped_cache_top.sv
// Top level of the direct-mapped cache with write-through backing memory.
`default_nettype none

// Usage:
// A transaction is accepted at a rising edge where start is high and busy is low;
// op_i, address_i and write_value_i are sampled at that edge.
// The result (hit_o, line_index_o, tag_value_o, read_value_o) is valid for the
// single cycle in which done_o is high; the receiver cannot hold it off.
// One transaction is in flight at a time.
// On a hit the controller steps through the address split, tag read, lookup, access and
// response states; a miss adds the block fill between lookup and access, one backing-memory
// read and one cache write per word.
// The address split runs through three constant divisions, each a registered
// multiply plus a correction step, which makes up most of the fixed part of the latency.
// busy drops in the cycle after done_o.
// After reset, busy stays high while backing memory is loaded with its initial
// pattern (word i holds MEM_WORDS - i) and every tag entry is cleared to invalid.
// Writes update the cached word and are written through to backing memory.
module direct_mapped_cache_top
  import dmc_pkg::*;
#(
  parameter int unsigned MEM_WORDS   = 4096,
  parameter int unsigned CACHE_WORDS = 256,
  parameter int unsigned BLOCK_WORDS = 8
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         start,
  output logic                        busy,
  input  wire                         op_i,
  input  wire        [ADDR_W-1:0]     address_i,
  input  wire signed [DATA_W-1:0]     write_value_i,
  output logic                        done_o,
  output logic                        hit_o,
  output logic       [LINE_OUT_W-1:0] line_index_o,
  output logic       [TAG_OUT_W-1:0]  tag_value_o,
  output logic signed [DATA_W-1:0]    read_value_o
);

  cmd_t cmd;
  sts_t sts;

  dmc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd),
    .sts_i  (sts)
  );

  dmc_datapath #(
    .MEM_WORDS   (MEM_WORDS),
    .CACHE_WORDS (CACHE_WORDS),
    .BLOCK_WORDS (BLOCK_WORDS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .op_i          (op_i),
    .address_i     (address_i),
    .write_value_i (write_value_i),
    .hit_o         (hit_o),
    .line_index_o  (line_index_o),
    .tag_value_o   (tag_value_o),
    .read_value_o  (read_value_o)
  );

endmodule

`default_nettype wire
